[hdl/asmt_pkg.sv]
// ----------------------------------------------------------------------------
// asmt_pkg
// Shared types and constants for the axis state matrix transform.
// ----------------------------------------------------------------------------
package asmt_pkg;

	localparam int AXES    = 4;
	localparam int AW      = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int NCOEF   = AXES * AXES;
	localparam int CW      = (AXES > 1) ? $clog2(NCOEF) : 1;
	localparam int PROD_W  = 64;
	localparam int ACC_W   = PROD_W + $clog2(AXES) + 1;
	localparam int SUM_W   = ACC_W - 16;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	typedef enum logic [1:0] {
		CMD_WR_FWD   = 2'd0,
		CMD_WR_INV   = 2'd1,
		CMD_VEC_CTRL = 2'd2,
		CMD_VEC_FDBK = 2'd3
	} cmd_t;

	typedef struct packed {
		logic          valid;
		logic          first;
		logic          last;
		logic          dir;
		logic [AW-1:0] row;
		logic [AW-1:0] col;
		logic [CW-1:0] coef;
	} mac_cmd_t;

endpackage

[hdl/asmt_ctrl.sv]
// ----------------------------------------------------------------------------
// asmt_ctrl
// Sequencer that walks the selected matrix one coefficient per cycle.
// ----------------------------------------------------------------------------
module asmt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        command,
	input  logic              last,
	output logic              busy,
	output asmt_pkg::mac_cmd_t mac
);
	import asmt_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t        state_q;
	logic          busy_q;
	logic          dir_q;
	logic [AW-1:0] row_q;
	logic [AW-1:0] col_q;
	logic [CW-1:0] coef_q;
	logic          go;
	logic          col_end;
	logic          row_end;

	assign go      = accept && last &&
		(command == CMD_VEC_CTRL || command == CMD_VEC_FDBK);
	assign col_end = (col_q == AW'(AXES - 1));
	assign row_end = (row_q == AW'(AXES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			dir_q   <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			coef_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q <= ST_RUN;
						busy_q  <= 1'b1;
						dir_q   <= (command == CMD_VEC_FDBK);
						row_q   <= '0;
						col_q   <= '0;
						coef_q  <= '0;
					end
				end
				ST_RUN: begin
					coef_q <= coef_q + CW'(1);
					if (col_end) begin
						col_q <= '0;
						row_q <= row_q + AW'(1);
						if (row_end) begin
							state_q <= ST_IDLE;
							busy_q  <= 1'b0;
						end
					end else begin
						col_q <= col_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

	always_comb begin
		mac.valid = (state_q == ST_RUN);
		mac.first = (col_q == '0);
		mac.last  = col_end;
		mac.dir   = dir_q;
		mac.row   = row_q;
		mac.col   = col_q;
		mac.coef  = coef_q;
	end

endmodule

[hdl/asmt_dp.sv]
// ----------------------------------------------------------------------------
// asmt_dp
// Coefficient and vector storage, multiply, accumulate, round and saturate.
// ----------------------------------------------------------------------------
module asmt_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         command,
	input  logic [5:0]         index,
	input  logic signed [31:0] coefficient,
	input  logic signed [31:0] position,
	input  logic signed [31:0] velocity,
	input  asmt_pkg::mac_cmd_t mac,
	output logic               valid,
	output logic [2:0]         axis,
	output logic signed [31:0] out_position,
	output logic signed [31:0] out_velocity,
	output logic               direction,
	output logic               saturated,
	output logic               final_res
);
	import asmt_pkg::*;

	logic [31:0] fwd_q [NCOEF];
	logic [31:0] inv_q [NCOEF];
	logic [31:0] pos_buf_q [AXES];
	logic [31:0] vel_buf_q [AXES];

	logic signed [PROD_W-1:0] pos_prod_s1;
	logic signed [PROD_W-1:0] vel_prod_s1;
	mac_cmd_t                 mac_s1;
	logic signed [ACC_W-1:0]  pos_acc_q;
	logic signed [ACC_W-1:0]  vel_acc_q;
	logic                     res_s2;
	logic                     dir_s2;
	logic [AW-1:0]            row_s2;

	logic                     wr_coef;
	logic                     wr_vec;
	logic signed [31:0]       coef_sel;
	logic signed [ACC_W-1:0]  pos_ext;
	logic signed [ACC_W-1:0]  vel_ext;
	logic signed [ACC_W-1:0]  pos_rnd;
	logic signed [ACC_W-1:0]  vel_rnd;
	logic signed [SUM_W-1:0]  pos_sum;
	logic signed [SUM_W-1:0]  vel_sum;
	logic                     pos_ovf;
	logic                     vel_ovf;
	logic [31:0]              pos_sat;
	logic [31:0]              vel_sat;

	assign wr_coef = accept && ({1'b0, index} < 7'(NCOEF));
	assign wr_vec  = accept && (index < 6'(AXES)) &&
		(command == CMD_VEC_CTRL || command == CMD_VEC_FDBK);

	// coefficient storage, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCOEF; i++) begin
				fwd_q[i] <= (i / AXES == i % AXES) ? ONE_Q16 : '0;
				inv_q[i] <= (i / AXES == i % AXES) ? ONE_Q16 : '0;
			end
		end else if (wr_coef) begin
			if (command == CMD_WR_FWD) begin
				fwd_q[index[CW-1:0]] <= coefficient;
			end else if (command == CMD_WR_INV) begin
				inv_q[index[CW-1:0]] <= coefficient;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				pos_buf_q[i] <= '0;
				vel_buf_q[i] <= '0;
			end
		end else if (wr_vec) begin
			pos_buf_q[index[AW-1:0]] <= position;
			vel_buf_q[index[AW-1:0]] <= velocity;
		end
	end

	// multiply stage
	assign coef_sel = mac.dir ? inv_q[mac.coef] : fwd_q[mac.coef];

	always_ff @(posedge clk) begin
		pos_prod_s1 <= coef_sel * $signed(pos_buf_q[mac.col]);
		vel_prod_s1 <= coef_sel * $signed(vel_buf_q[mac.col]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= '0;
		end else begin
			mac_s1 <= mac;
		end
	end

	// accumulate stage
	assign pos_ext = {{(ACC_W - PROD_W){pos_prod_s1[PROD_W-1]}}, pos_prod_s1};
	assign vel_ext = {{(ACC_W - PROD_W){vel_prod_s1[PROD_W-1]}}, vel_prod_s1};

	always_ff @(posedge clk) begin
		if (mac_s1.valid) begin
			pos_acc_q <= mac_s1.first ? pos_ext : pos_acc_q + pos_ext;
			vel_acc_q <= mac_s1.first ? vel_ext : vel_acc_q + vel_ext;
		end
		dir_s2 <= mac_s1.dir;
		row_s2 <= mac_s1.row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
		end else begin
			res_s2 <= mac_s1.valid && mac_s1.last;
		end
	end

	// round half up to q16.16, then clip to 32 bits
	assign pos_rnd = pos_acc_q + ACC_W'(32768);
	assign vel_rnd = vel_acc_q + ACC_W'(32768);
	assign pos_sum = pos_rnd[ACC_W-1:16];
	assign vel_sum = vel_rnd[ACC_W-1:16];
	assign pos_ovf = !((&pos_sum[SUM_W-1:31]) || !(|pos_sum[SUM_W-1:31]));
	assign vel_ovf = !((&vel_sum[SUM_W-1:31]) || !(|vel_sum[SUM_W-1:31]));
	assign pos_sat = pos_ovf ? {pos_sum[SUM_W-1], {31{!pos_sum[SUM_W-1]}}} : pos_sum[31:0];
	assign vel_sat = vel_ovf ? {vel_sum[SUM_W-1], {31{!vel_sum[SUM_W-1]}}} : vel_sum[31:0];

	logic        valid_q;
	logic [2:0]  axis_q;
	logic [31:0] out_pos_q;
	logic [31:0] out_vel_q;
	logic        dir_q;
	logic        sat_q;
	logic        final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= res_s2;
		end
	end

	always_ff @(posedge clk) begin
		axis_q    <= 3'(row_s2);
		out_pos_q <= pos_sat;
		out_vel_q <= vel_sat;
		dir_q     <= dir_s2;
		sat_q     <= pos_ovf || vel_ovf;
		final_q   <= (row_s2 == AW'(AXES - 1));
	end

	assign valid        = valid_q;
	assign axis         = axis_q;
	assign out_position = out_pos_q;
	assign out_velocity = out_vel_q;
	assign direction    = dir_q;
	assign saturated    = sat_q;
	assign final_res    = final_q;

endmodule

[hdl/axis_state_matrix_transform.sv]
// ----------------------------------------------------------------------------
// axis_state_matrix_transform
// Multiplies a buffered axis position/velocity vector by a forward or
// inverse Q16.16 coefficient matrix, one result per axis.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Coefficient writes
// and vector elements without last leave busy low. A vector element with
// last raises busy while one shared pair of 32x32 multipliers steps through
// the chosen matrix one coefficient per cycle; busy then drops and the next
// request may enter while the last results drain. Results come out one per
// row, each marked by valid for a single cycle; the receiver cannot stall,
// so every result must be captured on the cycle it appears.
module axis_state_matrix_transform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [5:0]         index,
	input  logic signed [31:0] coefficient,
	input  logic signed [31:0] position,
	input  logic signed [31:0] velocity,
	input  logic               last,
	output logic               valid,
	output logic [2:0]         axis,
	output logic signed [31:0] out_position,
	output logic signed [31:0] out_velocity,
	output logic               direction,
	output logic               saturated,
	output logic               final_res
);
	import asmt_pkg::*;

	logic     accept;
	mac_cmd_t mac;

	assign accept = start && !busy;

	asmt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.command (command),
		.last    (last),
		.busy    (busy),
		.mac     (mac)
	);

	asmt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.index        (index),
		.coefficient  (coefficient),
		.position     (position),
		.velocity     (velocity),
		.mac          (mac),
		.valid        (valid),
		.axis         (axis),
		.out_position (out_position),
		.out_velocity (out_velocity),
		.direction    (direction),
		.saturated    (saturated),
		.final_res    (final_res)
	);

endmodule

[hdl/asmt_checker.sv]
// ----------------------------------------------------------------------------
// asmt_checker
// Port-level checks on request and result sequencing.
// ----------------------------------------------------------------------------
module asmt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] command,
	input logic       last,
	input logic       valid,
	input logic [2:0] axis,
	input logic       final_res
);
	import asmt_pkg::*;

	a_final_row: assert property (@(posedge clk) disable iff (!arst_n)
		valid && final_res |-> axis == 3'(AXES - 1))
		else $error("final result not on last row");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last &&
		(command == CMD_VEC_CTRL || command == CMD_VEC_FDBK) |=> busy)
		else $error("vector with last did not start multiply");

	a_row_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		valid && axis != 3'd0 |->
		$past(valid, AXES) && $past(axis, AXES) == 3'(axis - 3'd1))
		else $error("result rows out of order or spacing");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && $past(last))
		else $error("busy raised without a final vector request");

endmodule

bind axis_state_matrix_transform asmt_checker u_asmt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.command   (command),
	.last      (last),
	.valid     (valid),
	.axis      (axis),
	.final_res (final_res)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives command and vector requests into axis_state_matrix_transform and
// checks every result row against a cycle-free model of both coefficient
// matrices and the shared axis buffer. It starts with directed cases: identity
// pass-through, extreme coefficients, rounding, saturation and out-of-range
// indexes. Random matrix loads and vector sequences with random idle gaps
// follow.
// ----------------------------------------------------------------------------
module testbench;
	import asmt_pkg::*;

	localparam int TARGET_REQUESTS = 220;
	localparam int CYCLE_LIMIT     = 300000;
	localparam int MAX_REPORTS     = 10;
	localparam logic signed [69:0] SUM_MAX = 70'sd2147483647;
	localparam logic signed [69:0] SUM_MIN = -70'sd2147483648;

	typedef struct {
		logic [2:0]  axis;
		logic [31:0] pos;
		logic [31:0] vel;
		logic        dir;
		logic        sat;
		logic        fin;
	} axis_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         command = CMD_WR_FWD;
	logic [5:0]         index = '0;
	logic signed [31:0] coefficient = '0;
	logic signed [31:0] position = '0;
	logic signed [31:0] velocity = '0;
	logic               last = 1'b0;
	logic               valid;
	logic [2:0]         axis;
	logic signed [31:0] out_position;
	logic signed [31:0] out_velocity;
	logic               direction;
	logic               saturated;
	logic               final_res;

	// model state
	logic signed [31:0] fwd_coef [NCOEF];
	logic signed [31:0] inv_coef [NCOEF];
	logic signed [31:0] pos_buf [AXES];
	logic signed [31:0] vel_buf [AXES];

	axis_row_t expected_rows [$];

	int  failures = 0;
	int  requests_sent = 0;
	int  vectors_sent = 0;
	int  rows_checked = 0;
	int  saturated_rows = 0;
	int  cycle_count = 0;
	bit  no_idle = 1'b0;

	axis_state_matrix_transform uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.index(index),
		.coefficient(coefficient),
		.position(position),
		.velocity(velocity),
		.last(last),
		.valid(valid),
		.axis(axis),
		.out_position(out_position),
		.out_velocity(out_velocity),
		.direction(direction),
		.saturated(saturated),
		.final_res(final_res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d rows outstanding", cycle_count,
				expected_rows.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// exact row product, rounded half up to q16.16, clip flag in bit 32
	function automatic logic [32:0] row_sum(input int row, input logic inv,
			input logic use_vel);
		logic signed [69:0] acc;
		logic signed [31:0] m;
		logic signed [31:0] x;
		longint prod;
		acc = '0;
		for (int j = 0; j < AXES; j++) begin
			m = inv ? inv_coef[row * AXES + j] : fwd_coef[row * AXES + j];
			x = use_vel ? vel_buf[j] : pos_buf[j];
			prod = longint'(m) * longint'(x);
			acc = acc + {{6{prod[63]}}, prod};
		end
		acc = (acc + 70'sd32768) >>> 16;
		if (acc > SUM_MAX)
			return {1'b1, 32'h7FFF_FFFF};
		if (acc < SUM_MIN)
			return {1'b1, 32'h8000_0000};
		return {1'b0, acc[31:0]};
	endfunction

	function automatic logic [31:0] rand_q16();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return $urandom_range(524288) - 262144;
		endcase
	endfunction

	task automatic send_request(input cmd_t cmd, input logic [5:0] idx,
			input logic [31:0] coef, input logic [31:0] pos, input logic [31:0] vel,
			input logic lst);
		logic [32:0] p_row;
		logic [32:0] v_row;
		logic        inv;
		int          gap;
		command <= cmd;
		index <= idx;
		coefficient <= coef;
		position <= pos;
		velocity <= vel;
		last <= lst;
		start <= 1'b1;
		do @(posedge clk); while (busy);

		// request taken at this edge
		if (cmd == CMD_WR_FWD || cmd == CMD_WR_INV) begin
			if (idx < NCOEF) begin
				requests_sent++;
				if (cmd == CMD_WR_FWD)
					fwd_coef[idx] = coef;
				else
					inv_coef[idx] = coef;
			end
		end else begin
			requests_sent++;
			if (idx < AXES) begin
				pos_buf[idx] = pos;
				vel_buf[idx] = vel;
			end
			if (lst) begin
				vectors_sent++;
				inv = (cmd == CMD_VEC_FDBK);
				for (int i = 0; i < AXES; i++) begin
					p_row = row_sum(i, inv, 1'b0);
					v_row = row_sum(i, inv, 1'b1);
					expected_rows.push_back('{axis: 3'(i), pos: p_row[31:0],
						vel: v_row[31:0], dir: inv, sat: p_row[32] | v_row[32],
						fin: (i == AXES - 1)});
				end
			end
		end

		// idle gap, mostly short, now and then long
		if (no_idle)
			gap = 0;
		else begin
			case ($urandom_range(19))
				0: gap = $urandom_range(60, 20);
				1, 2: gap = $urandom_range(10, 4);
				3, 4, 5, 6, 7, 8, 9, 10: gap = $urandom_range(3, 1);
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		axis_row_t exp_row;
		if (arst_n && valid) begin
			if (expected_rows.size() == 0) begin
				if (failures < MAX_REPORTS)
					$display("unexpected result: axis %0d pos %h vel %h", axis,
						out_position, out_velocity);
				failures++;
			end else begin
				exp_row = expected_rows.pop_front();
				rows_checked++;
				if (exp_row.sat)
					saturated_rows++;
				if (axis !== exp_row.axis || out_position !== exp_row.pos ||
						out_velocity !== exp_row.vel || direction !== exp_row.dir ||
						saturated !== exp_row.sat || final_res !== exp_row.fin) begin
					if (failures < MAX_REPORTS) begin
						$display("mismatch: expected axis %0d pos %h vel %h dir %b sat %b final %b",
							exp_row.axis, exp_row.pos, exp_row.vel, exp_row.dir,
							exp_row.sat, exp_row.fin);
						$display("          got      axis %0d pos %h vel %h dir %b sat %b final %b",
							axis, out_position, out_velocity, direction, saturated,
							final_res);
					end
					failures++;
				end
			end
		end
	end

	task automatic test_identity_passthrough();
		// reset matrices are identity, so each axis comes back unchanged
		send_request(CMD_VEC_CTRL, 6'd0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_request(CMD_VEC_CTRL, 6'd1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_request(CMD_VEC_CTRL, 6'd2, 32'h0, 32'h0000_0000, 32'h0001_0000, 1'b0);
		send_request(CMD_VEC_FDBK, 6'd3, 32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
	endtask

	task automatic test_coefficient_extremes();
		// last on a write is ignored
		send_request(CMD_WR_FWD, 6'd0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1);
		send_request(CMD_WR_FWD, 6'd1, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
		send_request(CMD_WR_FWD, 6'd5, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
		// half coefficient times one lsb lands exactly on the rounding point
		send_request(CMD_WR_FWD, 6'd10, 32'h0000_8000, 32'h0, 32'h0, 1'b0);
		send_request(CMD_WR_INV, 6'd15, 32'h8000_0000, 32'h0, 32'h0, 1'b0);
		send_request(CMD_WR_INV, 6'd0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1);
		send_request(CMD_VEC_CTRL, 6'd2, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
		// min times min saturates high
		send_request(CMD_VEC_FDBK, 6'd3, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
	endtask

	task automatic test_out_of_range_indexes();
		send_request(CMD_WR_FWD, 6'd16, 32'h1234_5678, 32'h0, 32'h0, 1'b0);
		send_request(CMD_WR_FWD, 6'd63, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
		send_request(CMD_WR_INV, 6'd63, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
		// axis index out of range still starts the multiply
		send_request(CMD_VEC_CTRL, 6'd63, 32'h0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
		send_request(CMD_VEC_FDBK, 6'd4, 32'h0, 32'h0100_0000, 32'h0100_0000, 1'b0);
		send_request(CMD_VEC_FDBK, 6'd5, 32'h0, 32'h0200_0000, 32'h0200_0000, 1'b1);
	endtask

	task automatic test_random_traffic();
		int   kind;
		int   n;
		cmd_t cmd;
		logic [5:0] idx;
		while (requests_sent < TARGET_REQUESTS) begin
			no_idle = ($urandom_range(3) == 0);
			kind = $urandom_range(99);
			if (kind < 20) begin
				// matrix load
				n = $urandom_range(6, 1);
				for (int k = 0; k < n; k++) begin
					cmd = $urandom_range(1) ? CMD_WR_INV : CMD_WR_FWD;
					send_request(cmd, 6'($urandom_range(NCOEF - 1)), rand_q16(),
						$urandom, $urandom, 1'($urandom_range(1)));
				end
			end else if (kind < 85) begin
				// vector sequence, some axes left from earlier vectors
				cmd = $urandom_range(1) ? CMD_VEC_FDBK : CMD_VEC_CTRL;
				n = $urandom_range(AXES - 1);
				for (int k = 0; k < n; k++)
					send_request(cmd, 6'($urandom_range(AXES - 1)), $urandom, rand_q16(),
						rand_q16(), 1'b0);
				idx = ($urandom_range(9) == 0) ? 6'($urandom_range(63, AXES)) :
					6'($urandom_range(AXES - 1));
				send_request(cmd, idx, $urandom, rand_q16(), rand_q16(), 1'b1);
			end else begin
				// noise
				send_request(cmd_t'($urandom_range(3)), 6'($urandom_range(63)), $urandom,
					$urandom, $urandom, 1'($urandom_range(1)));
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < NCOEF; i++) begin
			fwd_coef[i] = (i / AXES == i % AXES) ? ONE_Q16 : '0;
			inv_coef[i] = (i / AXES == i % AXES) ? ONE_Q16 : '0;
		end
		for (int i = 0; i < AXES; i++) begin
			pos_buf[i] = '0;
			vel_buf[i] = '0;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity_passthrough();
		test_coefficient_extremes();
		test_out_of_range_indexes();
		test_random_traffic();

		start <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		failures += expected_rows.size();

		$display("%0d requests sent, %0d vectors multiplied", requests_sent, vectors_sent);
		$display("%0d result rows checked, %0d of them saturated, %0d errors", rows_checked,
			saturated_rows, failures);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
